// ===== rtl/core/aeps_pkg.sv =====
package aeps_pkg;

  // Table geometry.
  localparam int TASK_SLOTS    = 16;
  localparam int PRIORITY_ROWS = 4;
  localparam int PID_W         = $clog2(TASK_SLOTS);
  localparam int ROW_W         = (PRIORITY_ROWS > 1) ? $clog2(PRIORITY_ROWS) : 1;
  localparam int OP_W          = 3;
  localparam int IN_TDATA_W    = 16;
  localparam int OUT_TDATA_W   = 16;
  localparam int CFG_W         = 2;

  // Event codes.
  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_CREATE  = 3'd1,
    OP_KILL    = 3'd2,
    OP_BLOCK   = 3'd3,
    OP_READY   = 3'd4,
    OP_TOGGLE  = 3'd5,
    OP_SETPRI  = 3'd6
  } op_t;

  // Per-slot task state.
  typedef enum logic [1:0] {
    TS_FREE    = 2'd0,
    TS_READY   = 2'd1,
    TS_BLOCKED = 2'd2
  } task_st_t;

  // Controller states.
  typedef enum logic [1:0] {
    CS_IDLE,
    CS_EXEC,
    CS_SCAN,
    CS_DONE
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic exec;
    logic scan;
    logic load_out;
  } aeps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scan;
    logic scan_done;
  } aeps_sts_t;

  // Index of the lowest set bit, zero when none is set.
  function automatic logic [PID_W-1:0] first_one(logic [TASK_SLOTS-1:0] v);
    logic [PID_W-1:0] idx;
    idx = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = PID_W'(i);
      end
    end
    return idx;
  endfunction

  // Saturate a priority to the last row.
  function automatic logic [ROW_W-1:0] clamp_row(logic [ROW_W-1:0] r);
    return (32'(r) >= PRIORITY_ROWS) ? ROW_W'(PRIORITY_ROWS - 1) : r;
  endfunction

  // One-hot slot mask.
  function automatic logic [TASK_SLOTS-1:0] slot_bit(logic [PID_W-1:0] pid);
    return TASK_SLOTS'(1) << pid;
  endfunction

endpackage

// ===== rtl/core/aeps_ctrl.sv =====
module aeps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  aeps_pkg::aeps_sts_t sts,
  output aeps_pkg::aeps_cmd_t cmd
);

  aeps_pkg::ctl_state_t state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aeps_pkg::CS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      aeps_pkg::CS_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = aeps_pkg::CS_EXEC;
        end
      end
      aeps_pkg::CS_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_scan ? aeps_pkg::CS_SCAN : aeps_pkg::CS_DONE;
      end
      aeps_pkg::CS_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = aeps_pkg::CS_DONE;
        end
      end
      aeps_pkg::CS_DONE: begin
        // Wait here while the previous result still sits in the output register.
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = aeps_pkg::CS_IDLE;
        end
      end
      default: begin
        state_nxt = aeps_pkg::CS_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/aeps_datapath.sv =====
module aeps_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  aeps_pkg::aeps_cmd_t            cmd,
  output aeps_pkg::aeps_sts_t            sts,
  input  logic [aeps_pkg::OP_W-1:0]      opcode,
  input  logic [aeps_pkg::PID_W-1:0]     target_pid,
  input  logic [aeps_pkg::ROW_W-1:0]     new_priority,
  input  logic                           cfg_valid,
  input  logic [aeps_pkg::CFG_W-1:0]     cfg_data,
  output logic [aeps_pkg::PID_W-1:0]     running_pid,
  output logic                           status,
  output logic [aeps_pkg::PID_W-1:0]     new_pid
);

  localparam int SLOTS = aeps_pkg::TASK_SLOTS;
  localparam int ROWS  = aeps_pkg::PRIORITY_ROWS;
  localparam int PW    = aeps_pkg::PID_W;
  localparam int RW    = aeps_pkg::ROW_W;
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [PW-1:0] LAST_COL = PW'(SLOTS - 1);

  // Latched request.
  aeps_pkg::op_t   op_r;
  logic [PW-1:0]   pid_r;
  logic [RW-1:0]   npri_r;

  // Scheduler state.
  logic [SLOTS-1:0]  tbl_r   [2][ROWS];
  logic [SLOTS-1:0]  tbl_nxt [2][ROWS];
  aeps_pkg::task_st_t tstate_r [SLOTS];
  logic [RW-1:0]     tpri_r   [SLOTS];
  logic [RW-1:0]     dflt_pri_r;
  logic [PW-1:0]     running_r, running_nxt;
  logic [RW-1:0]     scan_row_r, scan_row_nxt;
  logic [PW-1:0]     scan_col_r, scan_col_nxt;
  logic              active_r, active_nxt;
  logic [RW-1:0]     slice_r, slice_nxt;
  logic              started_r, started_nxt;
  logic              passes_r, passes_nxt;
  logic              status_r, status_nxt;
  logic [PW-1:0]     given_r, given_nxt;
  logic [PW-1:0]     out_running_r;
  logic              out_status_r;
  logic [PW-1:0]     out_given_r;

  // Table and slot write requests.
  logic              clr_en;
  logic [1:0]        clr_tbl;
  logic [RW-1:0]     clr_row;
  logic [SLOTS-1:0]  clr_bits;
  logic              set_en;
  logic              set_tbl;
  logic [RW-1:0]     set_row;
  logic [SLOTS-1:0]  set_bits;
  logic              ts_we;
  logic [PW-1:0]     ts_idx;
  aeps_pkg::task_st_t ts_val;
  logic              tp_we;
  logic [PW-1:0]     tp_idx;
  logic [RW-1:0]     tp_val;

  // Derived values.
  logic [SLOTS-1:0]  ready_vec, live_vec, free_vec;
  logic              create_hit;
  logic [PW-1:0]     create_slot;
  aeps_pkg::task_st_t pid_st;
  logic              pid_free;
  logic [RW-1:0]     pid_row, dflt_row, npri_row;
  aeps_pkg::task_st_t new_st;
  logic [SLOTS-1:0]  row_bits, col_mask, scan_mask, rdy_bits, low_mask, moved;
  logic              found;
  logic [PW-1:0]     first;
  logic [RW-1:0]     adv_row;
  logic [PW-1:0]     adv_col;
  logic              adv_active, adv_pass;
  logic              need_scan, scan_done;

  // Slot state vectors.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      ready_vec[i] = (tstate_r[i] == aeps_pkg::TS_READY);
      live_vec[i]  = (tstate_r[i] != aeps_pkg::TS_FREE);
    end
  end

  // Create looks for the first free slot above the idle slot.
  assign free_vec    = ~live_vec & ~SLOTS'(1);
  assign create_hit  = |free_vec;
  assign create_slot = aeps_pkg::first_one(free_vec);

  assign pid_st   = tstate_r[pid_r];
  assign pid_free = (pid_st == aeps_pkg::TS_FREE);
  assign pid_row  = aeps_pkg::clamp_row(tpri_r[pid_r]);
  assign dflt_row = aeps_pkg::clamp_row(dflt_pri_r);
  assign npri_row = aeps_pkg::clamp_row(npri_r);

  // New state for a state change event.
  always_comb begin
    case (op_r)
      aeps_pkg::OP_KILL:   new_st = aeps_pkg::TS_FREE;
      aeps_pkg::OP_READY:  new_st = aeps_pkg::TS_READY;
      aeps_pkg::OP_TOGGLE: new_st = (pid_st == aeps_pkg::TS_BLOCKED) ?
                                    aeps_pkg::TS_READY : aeps_pkg::TS_BLOCKED;
      default:             new_st = aeps_pkg::TS_BLOCKED;
    endcase
  end

  // One row of the scan: entries from the current column on, up to the first ready one.
  assign row_bits  = tbl_r[active_r][scan_row_r];
  assign col_mask  = {SLOTS{1'b1}} << scan_col_r;
  assign scan_mask = row_bits & col_mask;
  assign rdy_bits  = scan_mask & ready_vec;
  assign found     = |rdy_bits;
  assign first     = aeps_pkg::first_one(rdy_bits);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      low_mask[i] = !found || (PW'(i) <= first);
    end
  end

  assign moved = scan_mask & low_mask & live_vec;

  // First step of a scan, one position past the last pick.
  always_comb begin
    adv_row    = scan_row_r;
    adv_col    = scan_col_r + 1'b1;
    adv_active = active_r;
    adv_pass   = 1'b0;
    if (scan_col_r == LAST_COL) begin
      adv_col = '0;
      if (scan_row_r == LAST_ROW) begin
        adv_row    = '0;
        adv_active = ~active_r;
        adv_pass   = 1'b1;
      end else begin
        adv_row = scan_row_r + 1'b1;
      end
    end
  end

  // Event execution and scan steps.
  always_comb begin
    running_nxt  = running_r;
    scan_row_nxt = scan_row_r;
    scan_col_nxt = scan_col_r;
    active_nxt   = active_r;
    slice_nxt    = slice_r;
    started_nxt  = started_r;
    passes_nxt   = passes_r;
    status_nxt   = status_r;
    given_nxt    = given_r;
    clr_en       = 1'b0;
    clr_tbl      = 2'b00;
    clr_row      = '0;
    clr_bits     = '0;
    set_en       = 1'b0;
    set_tbl      = 1'b0;
    set_row      = '0;
    set_bits     = '0;
    ts_we        = 1'b0;
    ts_idx       = pid_r;
    ts_val       = new_st;
    tp_we        = 1'b0;
    tp_idx       = pid_r;
    tp_val       = npri_row;
    need_scan    = 1'b0;
    scan_done    = 1'b0;

    if (cmd.exec) begin
      status_nxt = 1'b0;
      given_nxt  = '0;
      case (op_r)
        aeps_pkg::OP_TICK: begin
          if (started_r) begin
            if (slice_r != '0) begin
              slice_nxt = slice_r - 1'b1;
            end else begin
              need_scan = 1'b1;
            end
          end
        end
        aeps_pkg::OP_CREATE: begin
          if (!create_hit) begin
            status_nxt = 1'b1;
          end else begin
            ts_we       = 1'b1;
            ts_idx      = create_slot;
            ts_val      = aeps_pkg::TS_READY;
            tp_we       = 1'b1;
            tp_idx      = create_slot;
            tp_val      = dflt_row;
            set_en      = 1'b1;
            set_tbl     = ~active_r;
            set_row     = dflt_row;
            set_bits    = aeps_pkg::slot_bit(create_slot);
            started_nxt = 1'b1;
            given_nxt   = create_slot;
          end
        end
        aeps_pkg::OP_KILL, aeps_pkg::OP_BLOCK, aeps_pkg::OP_READY,
        aeps_pkg::OP_TOGGLE: begin
          if (pid_free) begin
            status_nxt = 1'b1;
          end else begin
            ts_we = 1'b1;
            if (op_r == aeps_pkg::OP_KILL) begin
              clr_en   = 1'b1;
              clr_tbl  = 2'b11;
              clr_row  = pid_row;
              clr_bits = aeps_pkg::slot_bit(pid_r);
            end
            // A change to the running task ends its slice at once.
            if (pid_r == running_r) begin
              slice_nxt = '0;
              need_scan = started_r;
            end
          end
        end
        aeps_pkg::OP_SETPRI: begin
          if (pid_free) begin
            status_nxt = 1'b1;
          end else begin
            clr_en   = 1'b1;
            clr_tbl  = 2'b11;
            clr_row  = pid_row;
            clr_bits = aeps_pkg::slot_bit(pid_r);
            set_en   = 1'b1;
            set_tbl  = ~active_r;
            set_row  = npri_row;
            set_bits = aeps_pkg::slot_bit(pid_r);
            tp_we    = 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (need_scan) begin
        scan_row_nxt = adv_row;
        scan_col_nxt = adv_col;
        active_nxt   = adv_active;
        passes_nxt   = adv_pass;
      end
    end else if (cmd.scan) begin
      // Visited blocked entries and the pick move to the expired table.
      clr_en   = 1'b1;
      clr_tbl  = active_r ? 2'b10 : 2'b01;
      clr_row  = scan_row_r;
      clr_bits = moved;
      set_en   = 1'b1;
      set_tbl  = ~active_r;
      set_row  = scan_row_r;
      set_bits = moved;
      if (found) begin
        running_nxt  = first;
        scan_col_nxt = first;
        slice_nxt    = LAST_ROW - scan_row_r;
        scan_done    = 1'b1;
      end else begin
        scan_col_nxt = '0;
        if (scan_row_r == LAST_ROW) begin
          scan_row_nxt = '0;
          active_nxt   = ~active_r;
          if (passes_r) begin
            running_nxt = '0;
            scan_done   = 1'b1;
          end else begin
            passes_nxt = 1'b1;
          end
        end else begin
          scan_row_nxt = scan_row_r + 1'b1;
        end
      end
    end
  end

  assign sts.need_scan = need_scan;
  assign sts.scan_done = scan_done;

  // Per-row table update: clear first, then set.
  always_comb begin
    for (int t = 0; t < 2; t++) begin
      for (int r = 0; r < ROWS; r++) begin
        tbl_nxt[t][r] = tbl_r[t][r];
        if (clr_en && clr_tbl[t] && (clr_row == RW'(r))) begin
          tbl_nxt[t][r] = tbl_nxt[t][r] & ~clr_bits;
        end
        if (set_en && (set_tbl == 1'(t)) && (set_row == RW'(r))) begin
          tbl_nxt[t][r] = tbl_nxt[t][r] | set_bits;
        end
      end
    end
  end

  // Scheduler state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < 2; t++) begin
        for (int r = 0; r < ROWS; r++) begin
          tbl_r[t][r] <= '0;
        end
      end
      for (int i = 0; i < SLOTS; i++) begin
        tstate_r[i] <= aeps_pkg::TS_FREE;
        tpri_r[i]   <= '0;
      end
      dflt_pri_r <= '0;
      running_r  <= PW'(1);
      scan_row_r <= '0;
      scan_col_r <= '0;
      active_r   <= 1'b0;
      slice_r    <= LAST_ROW;
      started_r  <= 1'b0;
      passes_r   <= 1'b0;
    end else begin
      for (int t = 0; t < 2; t++) begin
        for (int r = 0; r < ROWS; r++) begin
          tbl_r[t][r] <= tbl_nxt[t][r];
        end
      end
      running_r  <= running_nxt;
      scan_row_r <= scan_row_nxt;
      scan_col_r <= scan_col_nxt;
      active_r   <= active_nxt;
      slice_r    <= slice_nxt;
      started_r  <= started_nxt;
      passes_r   <= passes_nxt;
      if (ts_we) begin
        tstate_r[ts_idx] <= ts_val;
      end
      if (tp_we) begin
        tpri_r[tp_idx] <= tp_val;
      end
      if (cfg_valid) begin
        dflt_pri_r <= cfg_data;
      end
    end
  end

  // Request, result and output payload registers.
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    given_r  <= given_nxt;
    if (cmd.load_in) begin
      op_r   <= aeps_pkg::op_t'(opcode);
      pid_r  <= target_pid;
      npri_r <= new_priority;
    end
    if (cmd.load_out) begin
      out_running_r <= running_r;
      out_status_r  <= status_r;
      out_given_r   <= given_r;
    end
  end

  assign running_pid = out_running_r;
  assign status      = out_status_r;
  assign new_pid     = out_given_r;

endmodule

// ===== rtl/core/active_expired_priority_scheduler.sv =====
// Priority scheduler with active and expired run tables.
// Input channel in_*: one request per event (tick, create, kill, block, make
// ready, block toggle, set priority). Output channel out_*: one result per
// request, giving the running task, the refusal flag and the slot that a
// create handed out. cfg_*: writes the priority row that new tasks enter;
// write it only while no request is in flight.
// Flow: an accepted request is latched, executed and its result loaded into the
// output register that drives out_tvalid. A tick that ends a slice, or a change
// to the running task, walks the active table one priority row per cycle before
// the result is loaded. No new request is taken until the last result is loaded.
// Reset: all slots free, tables empty, task 1 marked running with a full
// slice, default priority row 0; ticks do nothing until the first create.
// Stall: a result waits in the output register while out_tready is low. One
// further request is taken and worked; its result then waits until the
// output register frees, and no new request is taken meanwhile.
module active_expired_priority_scheduler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // opcode [2:0], target_pid [6:3], new_priority [8:7], zero fill above
  input  logic [aeps_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // running_pid [3:0], status [4], new_pid [8:5], zero fill above
  output logic [aeps_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [aeps_pkg::CFG_W-1:0]        cfg_data
);

  localparam int OPL = aeps_pkg::OP_W;
  localparam int PW  = aeps_pkg::PID_W;
  localparam int RW  = aeps_pkg::ROW_W;

  aeps_pkg::aeps_cmd_t cmd;
  aeps_pkg::aeps_sts_t sts;
  logic [PW-1:0]       running_pid;
  logic                status;
  logic [PW-1:0]       new_pid;

  assign cfg_ready = 1'b1;

  aeps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  aeps_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .opcode       (in_tdata[OPL-1:0]),
    .target_pid   (in_tdata[OPL+PW-1:OPL]),
    .new_priority (in_tdata[OPL+PW+RW-1:OPL+PW]),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .running_pid  (running_pid),
    .status       (status),
    .new_pid      (new_pid)
  );

  // Result packing.
  assign out_tdata = aeps_pkg::OUT_TDATA_W'({new_pid, status, running_pid});

`ifndef SYNTH
  // At most one datapath command per cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_in, cmd.exec, cmd.scan, cmd.load_out}))
    else $error("more than one datapath command in a cycle");

  // A result is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_tvalid || out_tready))
    else $error("result register overwritten");

  // A granted slot comes only with an accepted create.
  a_given_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (new_pid != '0)) |-> !status)
    else $error("slot given on a refused request");

  // No new request is taken in the cycle after execution.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> !in_tready)
    else $error("request taken while busy");
`endif

endmodule
